// ===== sv/stkdf_pkg.sv =====
`default_nettype none

package stkdf_pkg;

	// Largest frame accepted, in bytes (start byte through checksum)
	localparam int unsigned MAX_FRAME = 512;

	// Position counter must hold MAX_FRAME itself
	localparam int unsigned POS_W   = $clog2(MAX_FRAME + 1);
	localparam int unsigned INDEX_W = 9;
	localparam int unsigned LEN_W   = 17;

	localparam logic [7:0] START_BYTE = 8'd27;
	localparam logic [7:0] TOKEN_BYTE = 8'd14;

	// Frame overhead: start, seq, size hi, size lo, token, checksum
	localparam logic [LEN_W-1:0] FRAME_OVERHEAD = LEN_W'(6);

	// Positions counted after the byte is taken (byte index + 1)
	localparam logic [POS_W-1:0] POS_SIZE_HIGH = POS_W'(3);
	localparam logic [POS_W-1:0] POS_SIZE_LOW  = POS_W'(4);
	localparam logic [POS_W-1:0] POS_TOKEN     = POS_W'(5);

	typedef enum logic [1:0] {
		EV_BYTE = 2'd0,
		EV_GOOD = 2'd1,
		EV_BAD  = 2'd2,
		EV_DROP = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic                 emit;
		logic [7:0]           data;
		logic [INDEX_W-1:0]   index;
		event_kind_t          kind;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/stkdf_parser.sv =====
`default_nettype none

module stkdf_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [7:0]        data,
	output stkdf_pkg::result_t     result
);
	import stkdf_pkg::*;

	logic [POS_W-1:0] pos_q, pos_n, pos_inc;
	logic [POS_W-1:0] exp_len_q, exp_len_n;
	logic [7:0]       xor_q, xor_n;
	logic [7:0]       size_hi_q, size_hi_n;
	logic [LEN_W-1:0] len;
	logic             len_over;

	assign pos_inc  = pos_q + POS_W'(1);
	assign len      = {1'b0, size_hi_q, data} + FRAME_OVERHEAD;
	assign len_over = len > LEN_W'(MAX_FRAME);

	// Next state and result for the byte under evaluation
	always_comb begin
		pos_n        = pos_q;
		exp_len_n    = exp_len_q;
		xor_n        = xor_q;
		size_hi_n    = size_hi_q;
		result.emit  = 1'b0;
		result.data  = data;
		result.index = INDEX_W'(pos_q);
		result.kind  = EV_BYTE;

		if (pos_q == '0) begin
			// Hunting for start byte
			if (data == START_BYTE) begin
				result.emit = 1'b1;
				pos_n       = POS_W'(1);
				exp_len_n   = '0;
				xor_n       = data;
			end
		end else if (pos_q >= POS_W'(MAX_FRAME)) begin
			// Runaway frame
			result.emit = 1'b1;
			result.kind = EV_DROP;
			pos_n       = '0;
			exp_len_n   = '0;
		end else begin
			result.emit = 1'b1;
			pos_n       = pos_inc;
			xor_n       = xor_q ^ data;
			if (pos_inc == POS_SIZE_HIGH) begin
				size_hi_n = data;
			end else if (pos_inc == POS_SIZE_LOW) begin
				if (len_over) begin
					result.kind = EV_DROP;
					pos_n       = '0;
					exp_len_n   = '0;
				end else begin
					exp_len_n = POS_W'(len);
				end
			end else if (pos_inc == POS_TOKEN) begin
				if (data != TOKEN_BYTE) begin
					result.kind = EV_DROP;
					pos_n       = '0;
					exp_len_n   = '0;
				end
			end else if (exp_len_q != '0 && pos_inc == exp_len_q) begin
				// Checksum byte: XOR over whole frame must be zero
				result.kind = (xor_n == 8'd0) ? EV_GOOD : EV_BAD;
				pos_n       = '0;
				exp_len_n   = '0;
			end
		end
	end

	// Frame state, updated once per evaluated byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			exp_len_q <= '0;
			xor_q     <= '0;
			size_hi_q <= '0;
		end else if (en) begin
			pos_q     <= pos_n;
			exp_len_q <= exp_len_n;
			xor_q     <= xor_n;
			size_hi_q <= size_hi_n;
		end
	end

endmodule

`default_nettype wire

// ===== sv/stk500v2_frame_deframer.sv =====
// Path from rx_byte transfer to result: input register, then result register.
// Throughput: one byte per cycle while out_ready is high; the frame state update is a
// single pass of compare, 10-bit increment and 8-bit XOR between the input and result
// registers. Bytes that do not open a frame while hunting produce no result.
// Reset (arst_n low, asynchronous): both registers empty, deframer hunting,
// length, XOR and size byte cleared.
`default_nettype none

module stk500v2_frame_deframer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        rx_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             out_byte,
	output logic [stkdf_pkg::INDEX_W-1:0]          out_index,
	output logic [1:0]                             event_kind
);
	import stkdf_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv_s1;
	logic       in_xfer;
	result_t    res;

	// Stage 1 moves on when the result register is free or being emptied
	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_xfer  = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= rx_byte;
		end
	end

	stkdf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.data   (byte_s1),
		.result (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && res.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			out_byte   <= res.data;
			out_index  <= res.index;
			event_kind <= res.kind;
		end
	end

`ifndef SYNTH
	// A held stage-1 byte is not overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1))
		else $error("stage 1 byte lost while stalled");

	// Frame byte at index zero is always the start byte
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_index == '0 && event_kind == EV_BYTE |-> out_byte == START_BYTE)
		else $error("index zero without start byte");

	// Checksum verdict only after the header
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_GOOD || event_kind == EV_BAD)
		|-> out_index >= INDEX_W'(5))
		else $error("checksum verdict inside header");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_stk500v2_frame_deframer.sv =====
`default_nettype none

module tb_stk500v2_frame_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import stkdf_pkg::*;

	// Cycles to let pass after the last result (input and result registers plus margin)
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_ITEMS  = 300;
	localparam int unsigned NO_IDLE_ITEMS = 100;
	localparam int unsigned HOLD_CYCLES   = 300;

	typedef struct {
		logic [7:0]         data;
		logic [INDEX_W-1:0] index;
		event_kind_t        kind;
	} frame_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         out_byte;
	logic [INDEX_W-1:0] out_index;
	logic [1:0]         event_kind;

	// Deframer state mirrored by the predictor
	logic [POS_W-1:0] frame_pos;
	logic [POS_W-1:0] frame_len;
	logic [7:0]       frame_xor;
	logic [7:0]       size_hi;

	frame_result_t pending_results[$];

	bit          tx_idle_en;
	bit          rx_idle_en;
	int unsigned hold_cycles;
	int unsigned bytes_sent;
	int unsigned bytes_framed;
	int unsigned bytes_checked;
	int unsigned frames_good;
	int unsigned frames_bad;
	int unsigned frames_dropped;
	int unsigned errors;

	stk500v2_frame_deframer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_index  (out_index),
		.event_kind (event_kind)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Predict the result of one byte; returns 0 when the byte is ignored
	function automatic bit predict_deframe(input logic [7:0] c, output frame_result_t r);
		logic [16:0]      len;
		logic [POS_W-1:0] idx;
		r.data  = c;
		r.index = '0;
		r.kind  = EV_BYTE;
		if (frame_pos == '0) begin
			if (c != START_BYTE)
				return 1'b0;
			frame_pos = POS_W'(1);
			frame_len = '0;
			frame_xor = c;
			return 1'b1;
		end
		idx = frame_pos;
		r.index = idx[INDEX_W-1:0];
		if (frame_pos >= MAX_FRAME) begin
			frame_pos = '0;
			frame_len = '0;
			r.kind = EV_DROP;
			return 1'b1;
		end
		frame_pos = frame_pos + 1'b1;
		frame_xor = frame_xor ^ c;
		case (frame_pos)
			POS_SIZE_HIGH: size_hi = c;
			POS_SIZE_LOW: begin
				len = {1'b0, size_hi, c} + FRAME_OVERHEAD;
				if (len > MAX_FRAME) begin
					frame_pos = '0;
					frame_len = '0;
					r.kind = EV_DROP;
				end else
					frame_len = len[POS_W-1:0];
			end
			POS_TOKEN: begin
				if (c != TOKEN_BYTE) begin
					frame_pos = '0;
					frame_len = '0;
					r.kind = EV_DROP;
				end
			end
			default: begin
				if (frame_len != '0 && frame_pos == frame_len) begin
					r.kind = (frame_xor == 8'h00) ? EV_GOOD : EV_BAD;
					frame_pos = '0;
					frame_len = '0;
				end
			end
		endcase
		return 1'b1;
	endfunction

	// Offer one byte, with an optional idle burst first; wait for the transfer
	task automatic send_byte(input logic [7:0] b);
		frame_result_t r;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		if (predict_deframe(b, r)) begin
			pending_results.push_back(r);
			bytes_framed++;
		end
	endtask

	// Build a frame and send its first keep bytes; oversize frames carry the header only
	task automatic send_frame(input int unsigned size, input logic [7:0] token,
			input bit corrupt, input int unsigned keep);
		logic [7:0] frame_q[$];
		logic [7:0] sum;
		sum = 8'h00;
		frame_q.push_back(START_BYTE);
		frame_q.push_back(8'($urandom));
		frame_q.push_back(size[15:8]);
		frame_q.push_back(size[7:0]);
		frame_q.push_back(token);
		if (size + 6 <= MAX_FRAME) begin
			repeat (size)
				frame_q.push_back(8'($urandom));
			foreach (frame_q[i])
				sum = sum ^ frame_q[i];
			if (corrupt)
				sum = sum ^ 8'($urandom_range(1, 255));
			frame_q.push_back(sum);
		end
		if (keep > frame_q.size())
			keep = frame_q.size();
		for (int unsigned i = 0; i < keep; i++)
			send_byte(frame_q[i]);
	endtask

	// Stop offering and wait until every expected result has been checked
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string field, input int unsigned exp_v,
			input int unsigned act_v);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
		errors++;
	endtask

	// Extremes, ignored bytes, minimal frames, oversize and bad-token drops
	task automatic test_directed();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(START_BYTE - 8'd1);
		send_byte(START_BYTE + 8'd1);
		send_frame(0, TOKEN_BYTE, 1'b0, 6);
		send_frame(0, TOKEN_BYTE, 1'b1, 6);
		send_frame(0, TOKEN_BYTE ^ 8'h01, 1'b0, 5);
		send_frame(MAX_FRAME - 5, TOKEN_BYTE, 1'b0, 4);
		send_frame(16'hFFFF, TOKEN_BYTE, 1'b0, 4);
		wait_drained();
	endtask

	// Longest legal frame, then a minimal frame back to back
	task automatic test_frame_limits();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_frame(MAX_FRAME - 6, TOKEN_BYTE, 1'b0, MAX_FRAME);
		send_frame(0, TOKEN_BYTE, 1'b0, 6);
		wait_drained();
	endtask

	// Receiver stalls for a long stretch while frames keep coming
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_cycles = HOLD_CYCLES;
		repeat (6)
			send_frame($urandom_range(0, 8), TOKEN_BYTE, 1'b0, MAX_FRAME);
		wait_drained();
	endtask

	// Mostly well-formed frames with random content, plus noise and broken frames
	task automatic run_random_frames(input int unsigned target, input bit idling);
		int unsigned start_count;
		int unsigned pick;
		start_count = bytes_framed;
		while (bytes_framed - start_count < target) begin
			tx_idle_en = idling && ($urandom_range(0, 3) != 0);
			rx_idle_en = idling && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 6)
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			else if (pick < 10)
				send_frame($urandom_range(MAX_FRAME - 5, 16'hFFFF), TOKEN_BYTE, 1'b0, 4);
			else if (pick < 15)
				send_frame($urandom_range(0, 24), 8'($urandom), 1'b0, MAX_FRAME);
			else if (pick < 19)
				send_frame($urandom_range(0, 24), TOKEN_BYTE, 1'b0, $urandom_range(1, 10));
			else if (pick < 20)
				send_frame($urandom_range(100, MAX_FRAME - 6), TOKEN_BYTE,
					1'($urandom_range(0, 1)), MAX_FRAME);
			else if (pick < 30)
				send_frame($urandom_range(0, 24), TOKEN_BYTE, 1'b1, MAX_FRAME);
			else
				send_frame($urandom_range(0, 24), TOKEN_BYTE, 1'b0, MAX_FRAME);
		end
		wait_drained();
	endtask

	task automatic test_random();
		run_random_frames(RANDOM_ITEMS, 1'b1);
	endtask

	task automatic test_no_idle();
		run_random_frames(NO_IDLE_ITEMS, 1'b0);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
	endtask

	// Receiver: long hold-off, random stall bursts, or always ready
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (rx_idle_en && stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 14) - 1;
			end else
				out_ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expectation
	initial begin : result_checker
		frame_result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, byte %0d index %0d kind %0d",
						$time, out_byte, out_index, event_kind);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					bytes_checked++;
					if (out_byte !== exp_r.data)
						report_mismatch("out_byte", exp_r.data, out_byte);
					if (out_index !== exp_r.index)
						report_mismatch("out_index", exp_r.index, out_index);
					if (event_kind !== exp_r.kind)
						report_mismatch("event_kind", exp_r.kind, event_kind);
					case (exp_r.kind)
						EV_GOOD: frames_good++;
						EV_BAD:  frames_bad++;
						EV_DROP: frames_dropped++;
						default: ;
					endcase
				end
			end
		end
	end

	// Main sequence
	initial begin
		frame_pos      = '0;
		frame_len      = '0;
		frame_xor      = 8'h00;
		size_hi        = 8'h00;
		tx_idle_en     = 1'b0;
		rx_idle_en     = 1'b0;
		hold_cycles    = 0;
		bytes_sent     = 0;
		bytes_framed   = 0;
		bytes_checked  = 0;
		frames_good    = 0;
		frames_bad     = 0;
		frames_dropped = 0;
		errors         = 0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		rx_byte  <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_frame_limits();
		test_backpressure();
		test_random();
		test_no_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				pending_results.size());
			errors++;
		end
		$display("Sent %0d bytes, %0d inside frames; checked %0d results.",
			bytes_sent, bytes_framed, bytes_checked);
		$display("Frames closed good %0d, bad checksum %0d, dropped %0d; %0d errors.",
			frames_good, frames_bad, frames_dropped, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
